// File: rtl/core/iiws_pkg.sv
// ----------------------------------------------------------------------------
// iiws_pkg
// Shared types and constants for the integral image block.
// ----------------------------------------------------------------------------
package iiws_pkg;

  localparam int PIX_W    = 8;
  localparam int AREA_W   = 29;
  localparam int SQ_W     = 36;
  localparam int SIZE_W   = 11;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SIGNED  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_ENABLE = 2'd3;

  typedef struct packed {
    logic [SIZE_W-1:0] row_width;
    logic [SIZE_W-1:0] frame_height;
    logic              pixel_signed;
  } cfg_t;

  // per-pixel control that travels with the read of the row store
  typedef struct packed {
    logic first_row;
    logic row_end;
    logic frame_end;
  } pix_flags_t;

endpackage

// File: rtl/core/iiws_ram.sv
// ----------------------------------------------------------------------------
// iiws_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module iiws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/iiws_front.sv
// ----------------------------------------------------------------------------
// iiws_front
// Raster position counters and running row sums of pixels and squares.
// ----------------------------------------------------------------------------
module iiws_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int CNT_W     = $clog2(MAX_WIDTH),
  localparam int RCNT_W    = $clog2(MAX_HEIGHT),
  localparam int ACC_W     = CNT_W + 9,
  localparam int SQ_ACC_W  = CNT_W + 17
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [iiws_pkg::PIX_W-1:0]      pixel,
  input  iiws_pkg::cfg_t                  cfg,
  output logic [CNT_W-1:0]                cur_col,
  output logic [CNT_W-1:0]                col,
  output logic [ACC_W-1:0]                row_acc,
  output logic [SQ_ACC_W-1:0]             sq_acc,
  output iiws_pkg::pix_flags_t            flags
);

  localparam int CCMP_W = (CNT_W + 1 > iiws_pkg::SIZE_W) ? CNT_W + 1 : iiws_pkg::SIZE_W;
  localparam int RCMP_W = (RCNT_W + 1 > iiws_pkg::SIZE_W) ? RCNT_W + 1 : iiws_pkg::SIZE_W;

  logic [CNT_W-1:0]  col_cnt;
  logic [RCNT_W-1:0] row_cnt;
  logic [CCMP_W-1:0] col_plus;
  logic [RCMP_W-1:0] row_plus;
  logic              last_col;
  logic              last_row;
  logic              neg;
  logic [8:0]        pix9;
  logic [7:0]        mag;
  logic [15:0]       mag_sq;
  logic [ACC_W-1:0]  acc_base;
  logic [SQ_ACC_W-1:0] sq_base;

  // column of the pixel now on the input, used as the row store read address
  assign cur_col = col_cnt;

  always_comb begin
    neg      = cfg.pixel_signed & pixel[7];
    pix9     = {neg, pixel};
    mag      = neg ? 8'(-pixel) : pixel;  // 256 - raw fits in 8 bits (max 128)
    mag_sq   = mag * mag;
    acc_base = (col_cnt == '0) ? '0 : row_acc;
    sq_base  = (col_cnt == '0) ? '0 : sq_acc;
    col_plus = CCMP_W'(col_cnt) + CCMP_W'(1);
    row_plus = RCMP_W'(row_cnt) + RCMP_W'(1);
    // a zero size register makes every pixel the last one
    last_col = (col_plus >= CCMP_W'(cfg.row_width)) || (col_plus >= CCMP_W'(MAX_WIDTH));
    last_row = (row_plus >= RCMP_W'(cfg.frame_height)) || (row_plus >= RCMP_W'(MAX_HEIGHT));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      row_acc <= '0;
      sq_acc  <= '0;
    end else if (accept) begin
      row_acc <= acc_base + {{(ACC_W-9){pix9[8]}}, pix9};
      sq_acc  <= sq_base + {{(SQ_ACC_W-16){1'b0}}, mag_sq};
      if (last_col) begin
        col_cnt <= '0;
        row_cnt <= last_row ? '0 : row_cnt + RCNT_W'(1);
      end else begin
        col_cnt <= col_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col             <= col_cnt;
      flags.first_row <= (row_cnt == '0);
      flags.row_end   <= last_col;
      flags.frame_end <= last_col & last_row;
    end
  end

endmodule

// File: rtl/core/integral_image_with_squares.sv
// ----------------------------------------------------------------------------
// integral_image_with_squares
// Summed-area table over a raster pixel stream, with a squared-pixel table.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled and gives one
// result per pixel through stage 1 and the output register. The column
// sums of the last row live in one RAM (one write and one registered read
// port, MAX_WIDTH entries); each pixel reads its column as it enters and
// writes the new sum back as it moves into the output register, and a
// write that meets a read of the same column (rows of one pixel) is
// forwarded. No clearing pass: the first row of a frame reads zero from
// above. Write the registers only while idle.
module integral_image_with_squares #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 write_enable,
  input  logic [iiws_pkg::CFG_IDX_W-1:0]       reg_index,
  input  logic [iiws_pkg::SIZE_W-1:0]          write_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [iiws_pkg::PIX_W-1:0]           pixel,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [iiws_pkg::AREA_W-1:0]   area_sum,
  output logic [iiws_pkg::SQ_W-1:0]            square_area_sum,
  output logic                                 row_end,
  output logic                                 frame_end
);

  localparam int CNT_W    = $clog2(MAX_WIDTH);
  localparam int ACC_W    = CNT_W + 9;
  localparam int SQ_ACC_W = CNT_W + 17;
  localparam int AREA_W   = iiws_pkg::AREA_W;
  localparam int SQ_W     = iiws_pkg::SQ_W;
  localparam int MEM_W    = AREA_W + SQ_W;

  iiws_pkg::cfg_t       cfg;
  logic                 square_enable;
  logic                 accept;
  logic                 s1_valid;
  logic                 s1_adv;
  logic [CNT_W-1:0]     cur_col;
  logic [CNT_W-1:0]     s1_col;
  logic [ACC_W-1:0]     row_acc;
  logic [SQ_ACC_W-1:0]  sq_acc;
  iiws_pkg::pix_flags_t s1_flags;
  logic [MEM_W-1:0]     ram_q;
  logic [MEM_W-1:0]     above;
  logic [MEM_W-1:0]     new_sums;
  logic                 fwd_hit;
  logic [MEM_W-1:0]     fwd_data;
  logic [AREA_W-1:0]    area_new;
  logic [SQ_W-1:0]      sq_new;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_width    <= iiws_pkg::SIZE_W'(1024);
      cfg.frame_height <= iiws_pkg::SIZE_W'(1024);
      cfg.pixel_signed <= 1'b0;
      square_enable    <= 1'b1;
    end else if (write_enable) begin
      case (reg_index)
        iiws_pkg::CFG_ROW_WIDTH:     cfg.row_width    <= write_data;
        iiws_pkg::CFG_FRAME_HEIGHT:  cfg.frame_height <= write_data;
        iiws_pkg::CFG_PIXEL_SIGNED:  cfg.pixel_signed <= write_data[0];
        iiws_pkg::CFG_SQUARE_ENABLE: square_enable    <= write_data[0];
        default: ;
      endcase
    end
  end

  // handshake: stage 1 moves on when the output register is free or drains
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign accept   = in_valid && !in_stall;

  iiws_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .pixel   (pixel),
    .cfg     (cfg),
    .cur_col (cur_col),
    .col     (s1_col),
    .row_acc (row_acc),
    .sq_acc  (sq_acc),
    .flags   (s1_flags)
  );

  iiws_ram #(
    .WIDTH (MEM_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata (new_sums),
    .re    (accept),
    .raddr (cur_col),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // forward the write-back when the entering pixel reads the same column
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (accept) begin
      fwd_hit <= s1_adv && (s1_col == cur_col);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data <= new_sums;
    end
  end

  always_comb begin
    above    = s1_flags.first_row ? '0 : (fwd_hit ? fwd_data : ram_q);
    area_new = above[AREA_W-1:0] + {{(AREA_W-ACC_W){row_acc[ACC_W-1]}}, row_acc};
    sq_new   = above[MEM_W-1:AREA_W] + {{(SQ_W-SQ_ACC_W){1'b0}}, sq_acc};
    new_sums = {sq_new, area_new};
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      area_sum        <= area_new;
      square_area_sum <= square_enable ? sq_new : '0;
      row_end         <= s1_flags.row_end;
      frame_end       <= s1_flags.frame_end;
    end
  end

`ifndef ASSERT_OFF
  a_frame_end_on_row_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (row_end || !frame_end))
    else $error("frame end without row end");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> s1_valid)
    else $error("stage 1 item lost while held");

  a_fwd_only_when_reading: assert property (@(posedge clk) disable iff (rst)
    (accept && s1_adv && (s1_col == cur_col)) |=> fwd_hit)
    else $error("same-column write not forwarded");
`endif

endmodule
